@@ rtl/core/clas_pkg.sv @@
// Package for the CAN linear actuator slew block: command codes, register
// indexes, queue entry and configuration types. No dependencies.
`default_nettype none

package clas_pkg;

  localparam logic [7:0]  CMD_SET_LENGTH = 8'h20;
  localparam logic [7:0]  CMD_QUERY      = 8'h21;
  localparam logic [7:0]  REPLY_STATUS   = 8'h22;
  localparam logic        FLAG_AT_SET    = 1'b1;
  localparam logic        OP_IN_FRAME    = 1'b0;
  localparam logic        OP_IN_TICK     = 1'b1;
  localparam logic [3:0]  SET_MIN_BYTES  = 4'd3;
  localparam logic [3:0]  CMD_MIN_BYTES  = 4'd1;

  localparam logic [10:0] DEVICE_ID_RST  = 11'd0;
  localparam logic [15:0] MIN_LENGTH_RST = 16'd0;
  localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;
  localparam logic [15:0] STEP_RST       = 16'd10;
  localparam logic [15:0] INIT_LEN_RST   = 16'd0;

  typedef enum logic [2:0] {
    REG_DEVICE_ID,
    REG_MIN_LENGTH,
    REG_MAX_LENGTH,
    REG_STEP_PER_TICK,
    REG_INITIAL_LENGTH
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_QUERY
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] value;
  } q_entry_t;

  typedef struct packed {
    logic [10:0] device_id;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [15:0] step;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
  } preset_t;

endpackage

`default_nettype wire

@@ rtl/core/clas_front.sv @@
// Front end: decodes an incoming beat into a tick, a clamped set or a query.
// Depends on clas_pkg.
`default_nettype none

module clas_front (
  input  wire logic          op_i,
  input  wire logic [10:0]   frame_id_i,
  input  wire logic [3:0]    frame_len_i,
  input  wire logic [7:0]    cmd_byte_i,
  input  wire logic [7:0]    len_high_i,
  input  wire logic [7:0]    len_low_i,
  input  wire clas_pkg::cfg_t cfg_i,
  output logic               keep_o,
  output clas_pkg::q_entry_t entry_o
);
  import clas_pkg::*;

  logic        for_us;
  logic [15:0] want;
  logic [15:0] upper;

  always_comb begin
    for_us = (frame_id_i == cfg_i.device_id) && (frame_len_i >= CMD_MIN_BYTES);
    want   = {len_high_i, len_low_i};
    // Upper limit first, then the lower one, so that min wins if the limits cross.
    upper  = (want < cfg_i.max_len) ? want : cfg_i.max_len;

    keep_o        = 1'b0;
    entry_o.kind  = OP_TICK;
    entry_o.value = (upper > cfg_i.min_len) ? upper : cfg_i.min_len;

    if (op_i == OP_IN_TICK) begin
      keep_o       = 1'b1;
      entry_o.kind = OP_TICK;
    end else if (for_us) begin
      if (cmd_byte_i == CMD_SET_LENGTH && frame_len_i >= SET_MIN_BYTES) begin
        keep_o       = 1'b1;
        entry_o.kind = OP_SET;
      end else if (cmd_byte_i == CMD_QUERY) begin
        keep_o       = 1'b1;
        entry_o.kind = OP_QUERY;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/clas_queue.sv @@
// Short FIFO of decoded operations between the front and the back end.
// Depends on clas_pkg.
`default_nettype none

module clas_queue #(
  parameter int Depth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire clas_pkg::q_entry_t entry_i,
  output logic                    full_o,
  output logic                    valid_o,
  output clas_pkg::q_entry_t      entry_o,
  input  wire logic               pop_i
);
  import clas_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    ptr_next = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    full_o  = (count_q == CW'(Depth));
    valid_o = (count_q != '0);
    entry_o = mem_q[rd_ptr_q];

    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/clas_back.sv @@
// Back end: holds the actuator state, slews on ticks, applies set commands
// and drives the status reply register. Depends on clas_pkg.
`default_nettype none

module clas_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire clas_pkg::cfg_t     cfg_i,
  input  wire clas_pkg::preset_t  preset_i,
  input  wire logic               q_valid_i,
  input  wire clas_pkg::q_entry_t q_entry_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [10:0]             reply_id_o,
  output logic [7:0]              reply_code_o,
  output logic [15:0]             reply_length_o,
  output logic                    at_setpoint_o
);
  import clas_pkg::*;

  logic [15:0] cur_q, cur_d;
  logic [15:0] tgt_q, tgt_d;
  logic [31:0] cmd_total_q, cmd_total_d;
  logic        out_valid_q, out_valid_d;
  logic [10:0] id_q, id_d;
  logic [15:0] len_q, len_d;
  logic        at_q, at_d;
  logic        exec;
  logic [15:0] gap_up, gap_dn, slewed;

  always_comb begin
    gap_up = tgt_q - cur_q;
    gap_dn = cur_q - tgt_q;
    if (tgt_q >= cur_q) begin
      slewed = (gap_up <= cfg_i.step) ? tgt_q : cur_q + cfg_i.step;
    end else begin
      slewed = (gap_dn <= cfg_i.step) ? tgt_q : cur_q - cfg_i.step;
    end

    // A query may only go ahead when the reply register is free this cycle.
    exec    = q_valid_i && ((q_entry_i.kind != OP_QUERY) || !out_valid_q || out_ready_i);
    q_pop_o = exec;

    cur_d       = cur_q;
    tgt_d       = tgt_q;
    cmd_total_d = cmd_total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    id_d        = id_q;
    len_d       = len_q;
    at_d        = at_q;

    if (preset_i.valid) begin
      cur_d = preset_i.value;
      tgt_d = preset_i.value;
    end else if (exec) begin
      case (q_entry_i.kind)
        OP_TICK: begin
          cur_d = slewed;
        end
        OP_SET: begin
          tgt_d       = q_entry_i.value;
          cmd_total_d = cmd_total_q + 32'd1;
        end
        OP_QUERY: begin
          cmd_total_d = cmd_total_q + 32'd1;
          out_valid_d = 1'b1;
          id_d        = cfg_i.device_id;
          len_d       = cur_q;
          at_d        = (cur_q == tgt_q) ? FLAG_AT_SET : 1'b0;
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= INIT_LEN_RST;
      tgt_q       <= INIT_LEN_RST;
      cmd_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      cmd_total_q <= cmd_total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    len_q <= len_d;
    at_q  <= at_d;
  end

  assign out_valid_o    = out_valid_q;
  assign reply_id_o     = id_q;
  assign reply_code_o   = REPLY_STATUS;
  assign reply_length_o = len_q;
  assign at_setpoint_o  = at_q;

endmodule

`default_nettype wire

@@ rtl/core/can_linear_actuator_slew.sv @@
// CAN linear actuator slew model, top level: configuration registers, decoder,
// operation queue and execution back end. Depends on clas_pkg and its submodules.
// Throughput: one beat per cycle while the queue is not full; a query reply is
// offered once its beat has passed the queue register and then the reply register.
// A stalled reply holds back the next query and every beat queued behind it; the
// queue absorbs QueueDepth beats before the input stalls.
// Reset: asynchronous, active low; all but reply data and queue storage are reset.
`default_nettype none

module can_linear_actuator_slew #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [10:0] frame_id_i,
  input  wire logic [3:0]  frame_len_i,
  input  wire logic [7:0]  cmd_byte_i,
  input  wire logic [7:0]  len_high_i,
  input  wire logic [7:0]  len_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [10:0]      reply_id_o,
  output logic [7:0]       reply_code_o,
  output logic [15:0]      reply_length_o,
  output logic             at_setpoint_o
);
  import clas_pkg::*;

  cfg_t     cfg_q, cfg_d;
  preset_t  preset;
  logic     keep;
  q_entry_t front_entry, q_entry;
  logic     q_push, q_full, q_valid, q_pop;

  always_comb begin
    cfg_d        = cfg_q;
    preset.valid = 1'b0;
    preset.value = cfg_wdata_i;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEVICE_ID:      cfg_d.device_id = cfg_wdata_i[10:0];
        REG_MIN_LENGTH:     cfg_d.min_len   = cfg_wdata_i;
        REG_MAX_LENGTH:     cfg_d.max_len   = cfg_wdata_i;
        REG_STEP_PER_TICK:  cfg_d.step      = cfg_wdata_i;
        REG_INITIAL_LENGTH: preset.valid    = 1'b1;
        default:            cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id <= DEVICE_ID_RST;
      cfg_q.min_len   <= MIN_LENGTH_RST;
      cfg_q.max_len   <= MAX_LENGTH_RST;
      cfg_q.step      <= STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clas_front u_front (
    .op_i        (op_i),
    .frame_id_i  (frame_id_i),
    .frame_len_i (frame_len_i),
    .cmd_byte_i  (cmd_byte_i),
    .len_high_i  (len_high_i),
    .len_low_i   (len_low_i),
    .cfg_i       (cfg_q),
    .keep_o      (keep),
    .entry_o     (front_entry)
  );

  // Beats that decode to nothing are accepted and dropped here.
  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && in_ready_o && keep;

  clas_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  clas_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .preset_i       (preset),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_id_o     (reply_id_o),
    .reply_code_o   (reply_code_o),
    .reply_length_o (reply_length_o),
    .at_setpoint_o  (at_setpoint_o)
  );

  a_pop_needs_entry: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid
  ) else $error("queue popped while empty");

  a_reply_from_query: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && q_entry.kind == OP_QUERY)
  ) else $error("reply raised without a query being executed");

  a_full_stalls_push: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> !($past(q_push))
  ) else $error("push into a full queue");

endmodule

`default_nettype wire
